// File: hdl/axis_path_position_lookup_assert.svh
// ----------------------------------------------------------------------------
// axis path position lookup assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef AXIS_PATH_POSITION_LOOKUP_ASSERT_SVH
`define AXIS_PATH_POSITION_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define APL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define APL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// types, codes and constants shared by the path position lookup modules
// ----------------------------------------------------------------------------
package apl_pkg;

   localparam int unsigned MAX_CORNERS_DEFAULT = 32;

   // operation codes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   // heading codes
   localparam logic [1:0] HEAD_UP    = 2'd0;
   localparam logic [1:0] HEAD_DOWN  = 2'd1;
   localparam logic [1:0] HEAD_RIGHT = 2'd2;
   localparam logic [1:0] HEAD_LEFT  = 2'd3;

   // rotation quadrant codes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [7:0]  point_x;
      logic [7:0]  point_y;
      logic [1:0]  heading;
      logic [15:0] progress;
   } req_type;

   typedef struct packed {
      logic signed [17:0] pos_x;
      logic signed [17:0] pos_y;
      logic [1:0]         rotation_quadrant;
      logic               found;
      logic               reached_end;
      logic               table_full;
      logic               too_few_points;
   } rsp_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
      logic [1:0] heading;
   } corner_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND_COMMIT,
      ST_LOCATE_WALK
   } state_type;

   typedef enum logic [1:0] {
      RD_PREV,
      RD_FIRST,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [2:0] {
      RESP_NONE,
      RESP_APPEND,
      RESP_FULL,
      RESP_FEW,
      RESP_FOUND,
      RESP_MISS
   } resp_kind_type;

   typedef struct packed {
      logic          capture;
      rd_sel_type    rd_sel;
      logic          append_commit;
      logic          walk_step;
      resp_kind_type resp_kind;
   } cmd_type;

   typedef struct packed {
      logic is_locate;
      logic full;
      logic few;
      logic hit;
      logic last;
   } status_type;

   function automatic logic [1:0] heading_to_rot(input logic [1:0] hd);
      logic [1:0] rot;
      unique case (hd)
         HEAD_UP:    rot = ROT_270;
         HEAD_DOWN:  rot = ROT_90;
         HEAD_RIGHT: rot = ROT_0;
         default:    rot = ROT_180;
      endcase
      return rot;
   endfunction

endpackage

// File: hdl/apl_datapath.sv
// ----------------------------------------------------------------------------
// apl_datapath
// corner and segment memories, walk registers and result register
// ----------------------------------------------------------------------------
module apl_datapath
   import apl_pkg::*;
#(
   parameter int unsigned MAX_CORNERS = MAX_CORNERS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_item,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_item
);

   localparam int IW = $clog2(MAX_CORNERS);
   localparam int CW = $clog2(MAX_CORNERS + 1);

   corner_type corner_mem [MAX_CORNERS];
   logic [7:0] seglen_mem [MAX_CORNERS];

   req_type    req_ff;
   logic [CW-1:0] count_ff;
   logic [7:0] total_ff;
   logic [IW-1:0] idx_ff;
   logic [7:0] acc_ff;
   corner_type corner_rd_ff;
   logic [7:0] seglen_rd_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_strobe_ff;
   logic       rsp_strobe_in;

   req_type    req_cur;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] prev_addr;
   logic [7:0] next_acc;
   logic [7:0] seg_len;
   logic       reached;
   logic signed [17:0] seg_off;
   logic signed [17:0] base_x;
   logic signed [17:0] base_y;

   assign req_cur   = cmd.capture ? req_item : req_ff;
   assign prev_addr = IW'(count_ff - CW'(1));
   assign next_acc  = acc_ff + seglen_rd_ff;
   assign reached   = req_cur.progress > {total_ff, 8'h00};

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV:  rd_addr = prev_addr;
         RD_FIRST: rd_addr = '0;
         RD_NEXT:  rd_addr = idx_ff + IW'(1);
         default:  rd_addr = '0;
      endcase
   end

   // previous corner heading picks the axis of the closing segment
   always_comb begin
      if (corner_rd_ff.heading == HEAD_UP || corner_rd_ff.heading == HEAD_DOWN) begin
         seg_len = (corner_rd_ff.y > req_ff.point_y) ? corner_rd_ff.y - req_ff.point_y
                                                     : req_ff.point_y - corner_rd_ff.y;
      end else begin
         seg_len = (corner_rd_ff.x > req_ff.point_x) ? corner_rd_ff.x - req_ff.point_x
                                                     : req_ff.point_x - corner_rd_ff.x;
      end
   end

   assign status.is_locate = (req_item.operation == OP_LOCATE);
   assign status.full      = (count_ff == CW'(MAX_CORNERS));
   assign status.few       = (count_ff < CW'(2));
   assign status.hit       = (req_ff.progress[15:8] < next_acc);
   assign status.last      = ((CW + 1)'(idx_ff) + (CW + 1)'(2)) >= (CW + 1)'(count_ff);

   assign seg_off = signed'({2'b00, req_ff.progress}) - signed'({2'b00, acc_ff, 8'h00});
   assign base_x  = signed'({2'b00, corner_rd_ff.x, 8'h00});
   assign base_y  = signed'({2'b00, corner_rd_ff.y, 8'h00});

   always_comb begin
      rsp_in = '0;
      unique case (cmd.resp_kind)
         RESP_NONE, RESP_APPEND: begin
         end
         RESP_FULL: begin
            rsp_in.table_full = 1'b1;
         end
         RESP_FEW: begin
            rsp_in.reached_end    = reached;
            rsp_in.too_few_points = 1'b1;
         end
         RESP_FOUND: begin
            rsp_in.pos_x = base_x;
            rsp_in.pos_y = base_y;
            unique case (corner_rd_ff.heading)
               HEAD_UP:    rsp_in.pos_y = base_y - seg_off;
               HEAD_DOWN:  rsp_in.pos_y = base_y + seg_off;
               HEAD_RIGHT: rsp_in.pos_x = base_x + seg_off;
               default:    rsp_in.pos_x = base_x - seg_off;
            endcase
            rsp_in.rotation_quadrant = heading_to_rot(corner_rd_ff.heading);
            rsp_in.found             = 1'b1;
            rsp_in.reached_end       = reached;
         end
         RESP_MISS: begin
            rsp_in.reached_end = reached;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe_in = (cmd.resp_kind != RESP_NONE);

   always_ff @(posedge clock) begin
      corner_rd_ff <= corner_mem[rd_addr];
      seglen_rd_ff <= seglen_mem[rd_addr];
      if (cmd.append_commit) begin
         corner_mem[count_ff[IW-1:0]] <= '{x: req_ff.point_x, y: req_ff.point_y,
                                           heading: req_ff.heading};
         if (count_ff != '0) begin
            seglen_mem[prev_addr] <= seg_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         req_ff <= req_item;
         idx_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.walk_step) begin
         idx_ff <= idx_ff + IW'(1);
         acc_ff <= next_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.append_commit) begin
            count_ff <= count_ff + CW'(1);
            if (count_ff != '0) begin
               total_ff <= total_ff + seg_len;
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: hdl/apl_ctrl.sv
// ----------------------------------------------------------------------------
// apl_ctrl
// sequencer for append and locate transactions
// ----------------------------------------------------------------------------
module apl_ctrl
   import apl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.is_locate) begin
                  state_in = status.few ? ST_IDLE : ST_LOCATE_WALK;
               end else begin
                  state_in = status.full ? ST_IDLE : ST_APPEND_COMMIT;
               end
            end
         end
         ST_APPEND_COMMIT: state_in = ST_IDLE;
         ST_LOCATE_WALK: begin
            if (status.hit || status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy              = (state_ff != ST_IDLE);
      cmd.capture       = 1'b0;
      cmd.rd_sel        = RD_PREV;
      cmd.append_commit = 1'b0;
      cmd.walk_step     = 1'b0;
      cmd.resp_kind     = RESP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = start;
            cmd.rd_sel  = status.is_locate ? RD_FIRST : RD_PREV;
            if (start) begin
               if (status.is_locate && status.few) begin
                  cmd.resp_kind = RESP_FEW;
               end else if (!status.is_locate && status.full) begin
                  cmd.resp_kind = RESP_FULL;
               end
            end
         end
         ST_APPEND_COMMIT: begin
            cmd.append_commit = 1'b1;
            cmd.resp_kind     = RESP_APPEND;
         end
         ST_LOCATE_WALK: begin
            cmd.rd_sel = RD_NEXT;
            priority if (status.hit) begin
               cmd.resp_kind = RESP_FOUND;
            end else if (status.last) begin
               cmd.resp_kind = RESP_MISS;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hdl/axis_path_position_lookup.sv
// ----------------------------------------------------------------------------
// axis_path_position_lookup
// path corner table with append and arc-length position locate
// ----------------------------------------------------------------------------
//   channel   ports                      handshake
//   request   start, busy, req_item      taken when start high and busy low
//   response  rsp_strobe, rsp_item       one-cycle strobe per result, no back-pressure
//
// every transaction gives exactly one result
// full-table append and locate with fewer than two points: result in the cycle
//   after the transaction is taken, from the response register
// append: commit state, then response; one read and one write of the corner memory
// locate: walks the segments through the single read port of the segment length
//   memory, one per cycle, until a hit or the last segment; result then registered
// synchronous active-high reset clears the corner count, total length and
//   sequencer; the tables need no clearing pass
// ----------------------------------------------------------------------------
module axis_path_position_lookup
   import apl_pkg::*;
#(
   parameter int unsigned MAX_CORNERS = MAX_CORNERS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   // request transaction
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   // response transaction
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: idle, append commit, locate walk
   apl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // corner tables, walk accumulator and response register
   apl_datapath #(
      .MAX_CORNERS (MAX_CORNERS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// File: hdl/apl_checker.sv
// ----------------------------------------------------------------------------
// apl_checker
// port-level checks for the path position lookup, bound to the top level
// ----------------------------------------------------------------------------
`include "axis_path_position_lookup_assert.svh"

module apl_checker
   import apl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);

   logic accepted;
   logic answered;
   logic active_ff;
   logic full_shown;
   logic locate_flags;
   logic miss_shown;
   logic zero_pos;

   assign accepted     = start && !busy;
   assign answered     = rsp_strobe || busy;
   assign full_shown   = rsp_strobe && rsp_item.table_full;
   assign locate_flags = rsp_item.found || rsp_item.reached_end || rsp_item.too_few_points;
   assign miss_shown   = rsp_strobe && !rsp_item.found;
   assign zero_pos     = (rsp_item.pos_x == '0) && (rsp_item.pos_y == '0)
                         && (rsp_item.rotation_quadrant == ROT_0);

   // taken transaction or work in progress during the previous cycle
   always_ff @(posedge clock) begin
      active_ff <= accepted || busy;
   end

   // a taken transaction either answers at once or keeps the block busy
   `APL_ASSERT_NEXT(a_accept_progress, clock, reset, accepted, answered, "transaction stalled")

   // results only follow a taken transaction or busy work
   `APL_ASSERT_NOW(a_strobe_cause, clock, reset, rsp_strobe, active_ff, "stray result")

   // refused append carries no locate flags
   `APL_ASSERT_NOW(a_full_alone, clock, reset, full_shown, !locate_flags, "full with locate flags")

   // a result without found (miss, append, full or few) reports a zero position and quadrant
   `APL_ASSERT_NOW(a_miss_zero, clock, reset, miss_shown, zero_pos, "miss with nonzero position")

endmodule

bind axis_path_position_lookup apl_checker u_checker (.*);
